@@ hw/rtl/fifo_queue_with_statistics_macros.svh @@
// Assertion macros shared by the fifo_queue_with_statistics RTL.
`ifndef FIFO_QUEUE_WITH_STATISTICS_MACROS_SVH
`define FIFO_QUEUE_WITH_STATISTICS_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define FQS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fifo_queue_with_statistics: assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define FQS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fifo_queue_with_statistics: assertion failed");

`endif

@@ hw/rtl/fqs_pkg.sv @@
// Types, constants and width helpers for the FIFO queue with statistics.
package fqs_pkg;

    localparam int DATA_W          = 32;
    localparam int FRAC_W          = 8;
    localparam int MEAN_W          = 40;
    localparam int FLAG_W          = 4;
    localparam int DEF_QUEUE_DEPTH = 64;

    // Operation codes carried in s_axis_tuser
    typedef enum logic [1:0] {
        OP_ENQUEUE = 2'd0,
        OP_DEQUEUE = 2'd1,
        OP_CLEAR   = 2'd2,
        OP_QUERY   = 2'd3
    } op_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;    // latch the input beat
        logic apply;     // carry out the operation
        logic dq_fin;    // finish a dequeue with the slot just read
        logic start;     // set up scan and divider
        logic work;      // one scan / divide step
        logic load_out;  // load the result register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic deq_live;   // dequeue on a non-empty queue
        logic work_done;  // scan and divider both finished
    } sts_t;

    function automatic int ptr_width(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

    function automatic int occ_width(input int depth);
        return $clog2(depth + 1);
    endfunction

    function automatic int tot_width(input int depth);
        return DATA_W + $clog2(depth);
    endfunction

    function automatic int out_raw_width(input int depth);
        return 3 * DATA_W + MEAN_W + occ_width(depth) + tot_width(depth) + FLAG_W;
    endfunction

    // Result beat padded to whole bytes
    function automatic int out_width(input int depth);
        return ((out_raw_width(depth) + 7) / 8) * 8;
    endfunction

endpackage

@@ hw/rtl/fqs_ctrl.sv @@
// Controller state machine for the FIFO queue with statistics.
module fqs_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    input  fqs_pkg::sts_t sts,
    output fqs_pkg::cmd_t cmd
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_APPLY  = 6'b000010,
        ST_DQ_FIN = 6'b000100,
        ST_START  = 6'b001000,
        ST_WORK   = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_vld_reg;
    logic   out_vld_next;
    logic   out_free;

    // Result register can take a new beat
    assign out_free      = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_vld_reg;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                cmd.apply  = 1'b1;
                state_next = sts.deq_live ? ST_DQ_FIN : ST_START;
            end
            ST_DQ_FIN:
            begin
                cmd.dq_fin = 1'b1;
                state_next = ST_START;
            end
            ST_START:
            begin
                cmd.start  = 1'b1;
                state_next = ST_WORK;
            end
            ST_WORK:
            begin
                cmd.work = 1'b1;
                if (sts.work_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid flag
    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (cmd.load_out)
        begin
            out_vld_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
        end
    end

endmodule

@@ hw/rtl/fqs_dpath.sv @@
// Datapath: slot memory, pointers, running total, scan unit and Q8 divider.
module fqs_dpath
#(
    parameter int QUEUE_DEPTH = fqs_pkg::DEF_QUEUE_DEPTH
)
(
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  fqs_pkg::cmd_t                                     cmd,
    input  logic [fqs_pkg::DATA_W-1:0]                        s_axis_tdata,
    input  logic [1:0]                                        s_axis_tuser,
    output logic [fqs_pkg::out_width(QUEUE_DEPTH)-1:0]        m_axis_tdata,
    output fqs_pkg::sts_t                                     sts
);

    localparam int DATA_W = fqs_pkg::DATA_W;
    localparam int PTR_W  = fqs_pkg::ptr_width(QUEUE_DEPTH);
    localparam int OCC_W  = fqs_pkg::occ_width(QUEUE_DEPTH);
    localparam int TOT_W  = fqs_pkg::tot_width(QUEUE_DEPTH);
    localparam int DVD_W  = TOT_W + fqs_pkg::FRAC_W;
    localparam int DCNT_W = $clog2(DVD_W + 1);
    localparam int RAW_W  = fqs_pkg::out_raw_width(QUEUE_DEPTH);
    localparam int OUT_W  = fqs_pkg::out_width(QUEUE_DEPTH);

    // Slot memory, one write and one registered read port
    logic signed [DATA_W-1:0] mem [QUEUE_DEPTH];
    logic signed [DATA_W-1:0] rd_data_reg;
    logic [PTR_W-1:0]         rd_addr;
    logic                     mem_we;

    // Latched input beat
    fqs_pkg::op_t             op_reg;
    logic signed [DATA_W-1:0] value_reg;

    // Queue state
    logic [PTR_W-1:0]        rp_reg, rp_next;
    logic [PTR_W-1:0]        wp_reg, wp_next;
    logic [OCC_W-1:0]        count_reg, count_next;
    logic signed [TOT_W-1:0] total_reg, total_next;
    logic                    drop_reg, drop_next;
    logic                    has_room;

    // Scan unit
    logic [PTR_W-1:0]         sp_reg, sp_next;
    logic [OCC_W-1:0]         left_reg, left_next;
    logic                     rd_vld_reg, rd_vld_next;
    logic                     first_reg, first_next;
    logic signed [DATA_W-1:0] head_reg, head_next;
    logic signed [DATA_W-1:0] max_reg, max_next;
    logic signed [DATA_W-1:0] min_reg, min_next;
    logic                     found_reg, found_next;

    // Divider
    logic [OCC_W-1:0]  rem_reg, rem_next;
    logic [DVD_W-1:0]  quo_reg, quo_next;
    logic [DCNT_W-1:0] dcnt_reg, dcnt_next;
    logic              neg_reg, neg_next;
    logic [OCC_W:0]    trial;
    logic [OCC_W:0]    trial_diff;
    logic [TOT_W-1:0]  tot_mag;
    logic [DVD_W-1:0]  quo_signed;

    // Result register
    logic [OUT_W-1:0]  out_reg;
    logic [RAW_W-1:0]  out_raw;
    logic [fqs_pkg::MEAN_W-1:0] mean;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign has_room   = (count_reg < OCC_W'(QUEUE_DEPTH));
    assign mem_we     = cmd.apply && (op_reg == fqs_pkg::OP_ENQUEUE) && has_room;
    assign rd_addr    = cmd.apply ? rp_reg : sp_reg;
    assign tot_mag    = total_reg[TOT_W-1] ? (~total_reg + TOT_W'(1)) : total_reg;
    assign trial      = {rem_reg, quo_reg[DVD_W-1]};
    assign trial_diff = trial - {1'b0, count_reg};

    assign sts.deq_live  = (op_reg == fqs_pkg::OP_DEQUEUE) && (count_reg != '0);
    assign sts.work_done = (left_reg == '0) && !rd_vld_reg && (dcnt_reg == '0);

    // Memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wp_reg] <= value_reg;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Queue state update
    always_comb
    begin
        rp_next    = rp_reg;
        wp_next    = wp_reg;
        count_next = count_reg;
        total_next = total_reg;
        drop_next  = drop_reg;
        if (cmd.apply)
        begin
            drop_next = 1'b0;
            unique case (op_reg)
                fqs_pkg::OP_ENQUEUE:
                begin
                    if (has_room)
                    begin
                        wp_next    = ptr_inc(wp_reg);
                        count_next = count_reg + OCC_W'(1);
                        total_next = total_reg + TOT_W'(value_reg);
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                end
                fqs_pkg::OP_DEQUEUE:
                begin
                    // slot read issued now, finished in dq_fin
                end
                fqs_pkg::OP_CLEAR:
                begin
                    rp_next    = '0;
                    wp_next    = '0;
                    count_next = '0;
                    total_next = '0;
                end
                fqs_pkg::OP_QUERY:
                begin
                end
                default:
                begin
                end
            endcase
        end
        if (cmd.dq_fin)
        begin
            total_next = total_reg - TOT_W'(rd_data_reg);
            rp_next    = ptr_inc(rp_reg);
            count_next = count_reg - OCC_W'(1);
        end
    end

    // Scan over held entries, oldest first
    always_comb
    begin
        sp_next     = sp_reg;
        left_next   = left_reg;
        rd_vld_next = rd_vld_reg;
        first_next  = first_reg;
        head_next   = head_reg;
        max_next    = max_reg;
        min_next    = min_reg;
        found_next  = found_reg;
        if (cmd.start)
        begin
            sp_next     = rp_reg;
            left_next   = count_reg;
            rd_vld_next = 1'b0;
            first_next  = 1'b1;
            head_next   = '1;
            max_next    = {1'b1, {(DATA_W-1){1'b0}}};
            min_next    = {1'b0, {(DATA_W-1){1'b1}}};
            found_next  = 1'b0;
        end
        else if (cmd.work)
        begin
            rd_vld_next = (left_reg != '0);
            if (left_reg != '0)
            begin
                sp_next   = ptr_inc(sp_reg);
                left_next = left_reg - OCC_W'(1);
            end
            if (rd_vld_reg)
            begin
                first_next = 1'b0;
                if (first_reg)
                begin
                    head_next = rd_data_reg;
                end
                if (rd_data_reg > max_reg)
                begin
                    max_next = rd_data_reg;
                end
                if (rd_data_reg < min_reg)
                begin
                    min_next = rd_data_reg;
                end
                if (rd_data_reg == value_reg)
                begin
                    found_next = 1'b1;
                end
            end
        end
    end

    // Restoring divider: |total| * 256 / count, one quotient bit a cycle
    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dcnt_next = dcnt_reg;
        neg_next  = neg_reg;
        if (cmd.start)
        begin
            rem_next  = '0;
            quo_next  = {tot_mag, {fqs_pkg::FRAC_W{1'b0}}};
            neg_next  = total_reg[TOT_W-1];
            dcnt_next = (count_reg == '0) ? '0 : DCNT_W'(DVD_W);
        end
        else if (cmd.work && (dcnt_reg != '0))
        begin
            dcnt_next = dcnt_reg - DCNT_W'(1);
            if (!trial_diff[OCC_W])
            begin
                rem_next = trial_diff[OCC_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[OCC_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b0};
            end
        end
    end

    // Result packing, first field lowest
    assign quo_signed = neg_reg ? (~quo_reg + DVD_W'(1)) : quo_reg;
    assign mean       = (count_reg == '0) ? '0 : quo_signed[fqs_pkg::MEAN_W-1:0];
    assign out_raw    = {drop_reg,
                         (count_reg == OCC_W'(QUEUE_DEPTH)),
                         (count_reg == '0),
                         found_reg,
                         min_reg,
                         max_reg,
                         mean,
                         total_reg,
                         count_reg,
                         head_reg};
    assign m_axis_tdata = out_reg;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rp_reg     <= '0;
            wp_reg     <= '0;
            count_reg  <= '0;
            total_reg  <= '0;
            left_reg   <= '0;
            rd_vld_reg <= 1'b0;
            dcnt_reg   <= '0;
        end
        else
        begin
            rp_reg     <= rp_next;
            wp_reg     <= wp_next;
            count_reg  <= count_next;
            total_reg  <= total_next;
            left_reg   <= left_next;
            rd_vld_reg <= rd_vld_next;
            dcnt_reg   <= dcnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg    <= fqs_pkg::op_t'(s_axis_tuser);
            value_reg <= s_axis_tdata;
        end
        if (cmd.load_out)
        begin
            out_reg <= OUT_W'(out_raw);
        end
        drop_reg  <= drop_next;
        sp_reg    <= sp_next;
        first_reg <= first_next;
        head_reg  <= head_next;
        max_reg   <= max_next;
        min_reg   <= min_next;
        found_reg <= found_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        neg_reg   <= neg_next;
    end

endmodule

@@ hw/rtl/fifo_queue_with_statistics.sv @@
// Top level of the FIFO queue with statistics: controller plus datapath.
//
// Each input beat carries an operation (enqueue, dequeue, clear, query) and a
// 32-bit value; after the operation one result beat reports head, occupancy,
// exact sum, Q8 mean, max, min, search hit and empty/full/dropped flags.
// One item is worked at a time. The scan reads the held entries one per cycle
// through the single read port of the slot memory, while a restoring divider
// forms one mean bit per cycle alongside, W = 40 + log2(QUEUE_DEPTH) quotient
// bits in all (46 at the default depth of 64). A dequeue that removes an entry
// first finishes it in a state of its own. A finished result sits in an output
// register, so the next beat is taken while it waits.
`include "fifo_queue_with_statistics_macros.svh"

module fifo_queue_with_statistics
#(
    parameter int QUEUE_DEPTH = fqs_pkg::DEF_QUEUE_DEPTH
)
(
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       s_axis_tvalid,
    output logic                                       s_axis_tready,
    // value
    input  logic [fqs_pkg::DATA_W-1:0]                 s_axis_tdata,
    // op
    input  logic [1:0]                                 s_axis_tuser,
    output logic                                       m_axis_tvalid,
    input  logic                                       m_axis_tready,
    // head_value, occupancy, total, mean_q8, largest, smallest,
    // found, is_empty, is_full, dropped, zero pad
    output logic [fqs_pkg::out_width(QUEUE_DEPTH)-1:0] m_axis_tdata
);

    fqs_pkg::cmd_t cmd;
    fqs_pkg::sts_t sts;

    fqs_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .sts           (sts),
        .cmd           (cmd)
    );

    fqs_dpath
    #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    )
    u_dpath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tdata (m_axis_tdata),
        .sts          (sts)
    );

    // One item in flight: no beat taken right after another
    `FQS_ASSERT_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    // A result never overwrites one still waiting
    `FQS_ASSERT_IMPL(a_no_overwrite, cmd.load_out, !m_axis_tvalid || m_axis_tready)
    // Output valid only rises after a result load
    `FQS_ASSERT_IMPL(a_valid_from_load, $rose(m_axis_tvalid), $past(cmd.load_out))

endmodule
